// File: hw/rtl/pkrs_pkg.sv
`default_nettype none
package pkrs_pkg;

    localparam int MEM_BYTES          = 8192;
    localparam int MAX_VALUE_BYTES    = 256;
    localparam int CHUNK_HEADER_BYTES = 32;
    localparam int ALIGN_BYTES        = 8;
    localparam int AREA_HEADER_BYTES  = 40;

    localparam int MEM_WORDS  = MEM_BYTES / 8;
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int PTR_W      = MEM_AW + 1;
    localparam int STG_WORDS  = MAX_VALUE_BYTES / 8;
    localparam int STG_AW     = $clog2(STG_WORDS);
    localparam int LEN_W      = $clog2(MAX_VALUE_BYTES + 1);
    localparam int NW_W       = LEN_W - 2;
    localparam int RW_W       = $clog2(MAX_VALUE_BYTES / 8 + 3);
    localparam int COST_W     = $clog2(MAX_VALUE_BYTES + CHUNK_HEADER_BYTES + ALIGN_BYTES + 1);
    localparam int REG_W      = 14;
    localparam int JOBQ_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_TOOLONG  = 3'd3,
        ST_STAGED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        JOB_STAGED,
        JOB_TOOLONG,
        JOB_PUT,
        JOB_GET,
        JOB_TEST,
        JOB_REMOVE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [63:0]       key;
        logic [LEN_W-1:0]  len;
        logic [63:0]       tail;
    } t_job;

    function automatic logic [COST_W-1:0] rec_cost(input logic [LEN_W-1:0] len);
        logic [COST_W-1:0] s;
        s = COST_W'(len) + COST_W'(CHUNK_HEADER_BYTES - 1);
        return ((s >> 3) << 3) + COST_W'(ALIGN_BYTES);
    endfunction

    function automatic logic [RW_W-1:0] rec_words(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] s;
        s = {1'b0, len} + (LEN_W+1)'(7);
        return RW_W'(s >> 3) + RW_W'(2);
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[8*i +: 8] = 8'hff;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/packed_keyed_record_store.sv
// channel   | signals                                              | transfer
// ----------+------------------------------------------------------+-------------------------
// command   | i_start, o_busy, i_command, i_key, i_data_word,      | i_start && !o_busy
//           | i_byte_count, i_last_word                            |
// result    | o_strobe, o_status, o_found, o_value_word,           | every o_strobe cycle
//           | o_value_bytes, o_last_result                         |
// config    | i_cfg_we, i_cfg_wdata (region_bytes)                 | i_cfg_we
//
// staged put words and too-long commits are answered from idle, without a walk of the store
// lookup walks each record through S_FKEY, S_FLEN and S_FCHK; remove then shifts later words down in S_MOVE
// put appends through S_APCHK, S_APLEN, S_APDAT and S_APTAIL; get gives one word per cycle
// the record memory takes one registered read and one write per cycle
// synchronous reset empties the store; no clearing pass, memory is only read where written
// results cannot be stalled; o_busy rises when the job queue is full or a commit is pending
`default_nettype none
module packed_keyed_record_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [1:0]                 i_command,
    input  wire logic signed [63:0]         i_key,
    input  wire logic [63:0]                i_data_word,
    input  wire logic [3:0]                 i_byte_count,
    input  wire logic                       i_last_word,
    input  wire logic                       i_cfg_we,
    input  wire logic [pkrs_pkg::REG_W-1:0] i_cfg_wdata,
    output logic                            o_strobe,
    output logic [2:0]                      o_status,
    output logic                            o_found,
    output logic [63:0]                     o_value_word,
    output logic [3:0]                      o_value_bytes,
    output logic                            o_last_result
);
    import pkrs_pkg::*;

    logic              accept;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    logic              commit_busy;
    logic              commit_done;
    logic [STG_AW-1:0] stg_raddr;
    logic [63:0]       stg_rdata;
    t_job              f_job;
    t_job              q_job;

    assign o_busy = q_full || commit_busy;
    assign accept = i_start && !o_busy;

    pkrs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last_word   (i_last_word),
        .i_cfg_we      (i_cfg_we),
        .i_commit_done (commit_done),
        .i_stg_raddr   (stg_raddr),
        .o_stg_rdata   (stg_rdata),
        .o_commit_busy (commit_busy),
        .o_job         (f_job)
    );

    pkrs_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    pkrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_stg_raddr   (stg_raddr),
        .i_stg_rdata   (stg_rdata),
        .o_commit_done (commit_done),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_value_word  (o_value_word),
        .o_value_bytes (o_value_bytes),
        .o_last_result (o_last_result)
    );

endmodule
`default_nettype wire

// File: hw/rtl/pkrs_front.sv
`default_nettype none
module pkrs_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [1:0]                 i_command,
    input  wire logic [63:0]                i_key,
    input  wire logic [63:0]                i_data_word,
    input  wire logic [3:0]                 i_byte_count,
    input  wire logic                       i_last_word,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_commit_done,
    input  wire logic [pkrs_pkg::STG_AW-1:0] i_stg_raddr,
    output logic [63:0]                     o_stg_rdata,
    output logic                            o_commit_busy,
    output pkrs_pkg::t_job                  o_job
);
    import pkrs_pkg::*;

    logic [63:0]      r_stg [STG_WORDS];
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic [63:0]      r_acc;
    logic             r_commit_busy;

    logic [3:0]       n;
    logic [3:0]       total;
    logic [127:0]     comb_w;
    logic [LEN_W:0]   sum_len;
    logic             ovf;
    logic             full_w;
    logic [63:0]      acc_nx;
    logic             stg_we;

    always_comb begin
        n       = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        total   = {1'b0, r_len[2:0]} + n;
        comb_w  = {64'b0, r_acc} | ({64'b0, i_data_word & byte_mask(n)} << {r_len[2:0], 3'b000});
        sum_len = {1'b0, r_len} + (LEN_W+1)'(n);
        ovf     = r_ovf || (sum_len > (LEN_W+1)'(MAX_VALUE_BYTES));
        full_w  = total >= 4'd8;
        acc_nx  = full_w ? comb_w[127:64] : comb_w[63:0];
        stg_we  = i_accept && (t_cmd'(i_command) == CMD_PUT) && !ovf && full_w;
    end

    always_comb begin
        o_job.key  = i_key;
        o_job.len  = sum_len[LEN_W-1:0];
        o_job.tail = acc_nx;
        unique case (t_cmd'(i_command))
            CMD_PUT:    o_job.kind = !i_last_word ? JOB_STAGED : (ovf ? JOB_TOOLONG : JOB_PUT);
            CMD_GET:    o_job.kind = JOB_GET;
            CMD_TEST:   o_job.kind = JOB_TEST;
            CMD_REMOVE: o_job.kind = JOB_REMOVE;
            default:    o_job.kind = JOB_GET;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            r_stg[r_len[STG_AW+2:3]] <= comb_w[63:0];
        end
        o_stg_rdata <= r_stg[i_stg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_len         <= '0;
            r_ovf         <= 1'b0;
            r_acc         <= '0;
            r_commit_busy <= 1'b0;
        end else begin
            if (i_commit_done) r_commit_busy <= 1'b0;
            if (i_accept) begin
                if (t_cmd'(i_command) == CMD_PUT && !i_last_word) begin
                    r_ovf <= ovf;
                    if (!ovf) begin
                        r_len <= sum_len[LEN_W-1:0];
                        r_acc <= acc_nx;
                    end
                end else begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                    r_acc <= '0;
                    if (t_cmd'(i_command) == CMD_PUT && !ovf) r_commit_busy <= 1'b1;
                end
            end
        end
    end

    assign o_commit_busy = r_commit_busy;

endmodule
`default_nettype wire

// File: hw/rtl/pkrs_jobq.sv
`default_nettype none
module pkrs_jobq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pkrs_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output pkrs_pkg::t_job      o_job
);
    import pkrs_pkg::*;

    localparam int QA = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

    t_job            r_q [JOBQ_DEPTH];
    logic [QA-1:0]   r_wp;
    logic [QA-1:0]   r_rp;
    logic [QA:0]     r_cnt;

    function automatic logic [QA-1:0] inc(input logic [QA-1:0] a);
        return (a == QA'(JOBQ_DEPTH - 1)) ? '0 : a + QA'(1);
    endfunction

    assign o_full  = r_cnt == (QA+1)'(JOBQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= inc(r_wp);
            if (i_pop)  r_rp <= inc(r_rp);
            r_cnt <= r_cnt + (QA+1)'(i_push) - (QA+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pkrs_back.sv
`default_nettype none
module pkrs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pkrs_pkg::REG_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_job_valid,
    input  wire pkrs_pkg::t_job              i_job,
    output logic                             o_pop,
    output logic [pkrs_pkg::STG_AW-1:0]      o_stg_raddr,
    input  wire logic [63:0]                 i_stg_rdata,
    output logic                             o_commit_done,
    output logic                             o_strobe,
    output logic [2:0]                       o_status,
    output logic                             o_found,
    output logic [63:0]                      o_value_word,
    output logic [3:0]                       o_value_bytes,
    output logic                             o_last_result
);
    import pkrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FKEY, S_FLEN, S_FCHK, S_MOVE, S_APCHK, S_APLEN, S_APDAT, S_APTAIL, S_GET
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [63:0]       r_mem [MEM_WORDS];
    logic [63:0]       r_rdata;
    logic [PTR_W-1:0]  r_pe;
    logic [REG_W-1:0]  r_free;
    logic [PTR_W-1:0]  r_p;
    logic [PTR_W-1:0]  r_src;
    logic [PTR_W-1:0]  r_dst;
    logic              r_mv;
    logic              r_hit;
    logic [LEN_W-1:0]  r_l;
    logic [RW_W-1:0]   r_rw;
    logic [COST_W-1:0] r_rc;
    logic [NW_W-1:0]   r_k;
    logic [NW_W-1:0]   r_wk;
    logic              r_sv;
    logic              r_gv;
    logic [3:0]        r_gnb;
    logic              r_glast;

    logic              wen;
    logic [MEM_AW-1:0] waddr;
    logic [63:0]       wdata;
    logic [MEM_AW-1:0] raddr;
    logic [LEN_W-1:0]  cur_l;
    logic [NW_W-1:0]   full_n;
    logic [NW_W-1:0]   g_nw;
    logic [COST_W-1:0] put_c;
    logic              put_fail;
    logic              mv_rd;
    logic              ap_rd;
    logic              g_rd;
    logic [LEN_W-1:0]  g_rem;
    logic [PTR_W-1:0]  pe_base;
    logic [REG_W:0]    eff;

    always_comb begin
        cur_l    = (r_rdata[15:0] > 16'(MAX_VALUE_BYTES)) ? LEN_W'(MAX_VALUE_BYTES)
                                                           : r_rdata[LEN_W-1:0];
        full_n   = NW_W'(r_job.len >> 3);
        g_nw     = NW_W'(({1'b0, r_l} + (LEN_W+1)'(7)) >> 3);
        put_c    = rec_cost(r_job.len);
        put_fail = r_free < REG_W'(put_c);
        mv_rd    = (r_state == S_MOVE) && (r_src < r_pe);
        ap_rd    = (r_state == S_APDAT) && (r_k < full_n);
        g_rd     = (r_state == S_GET) && (r_k < g_nw);
        g_rem    = r_l - LEN_W'({r_k, 3'b000});
        pe_base  = r_pe + PTR_W'(2);
        o_pop    = (r_state == S_IDLE) && i_job_valid;
        o_stg_raddr   = r_k[STG_AW-1:0];
        o_commit_done = (r_state == S_APTAIL) || ((r_state == S_APCHK) && put_fail);
        eff = (i_cfg_wdata > REG_W'(MEM_BYTES)) ? (REG_W+1)'(MEM_BYTES) : {1'b0, i_cfg_wdata};
    end

    always_comb begin
        raddr = r_p[MEM_AW-1:0];
        wen   = 1'b0;
        waddr = r_dst[MEM_AW-1:0];
        wdata = r_rdata;
        unique case (r_state)
            S_FLEN:   raddr = MEM_AW'(r_p + PTR_W'(1));
            S_MOVE: begin
                raddr = r_src[MEM_AW-1:0];
                wen   = r_mv;
            end
            S_APCHK: begin
                wen   = !put_fail;
                waddr = r_pe[MEM_AW-1:0];
                wdata = r_job.key;
            end
            S_APLEN: begin
                wen   = 1'b1;
                waddr = MEM_AW'(r_pe + PTR_W'(1));
                wdata = 64'(r_job.len);
            end
            S_APDAT: begin
                wen   = r_sv;
                waddr = MEM_AW'(pe_base + PTR_W'(r_wk));
                wdata = i_stg_rdata;
            end
            S_APTAIL: begin
                wen   = r_job.len[2:0] != 3'd0;
                waddr = MEM_AW'(pe_base + PTR_W'(full_n));
                wdata = r_job.tail;
            end
            S_GET:    raddr = MEM_AW'(r_p + PTR_W'(2) + PTR_W'(r_k));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pe     <= '0;
            r_free   <= REG_W'(MEM_BYTES - AREA_HEADER_BYTES);
            o_strobe <= 1'b0;
        end else if (i_cfg_we) begin
            r_state  <= S_IDLE;
            r_pe     <= '0;
            r_free   <= (eff > (REG_W+1)'(AREA_HEADER_BYTES))
                        ? REG_W'(eff - (REG_W+1)'(AREA_HEADER_BYTES)) : '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe      <= 1'b0;
            o_status      <= ST_OK;
            o_found       <= 1'b0;
            o_value_word  <= '0;
            o_value_bytes <= '0;
            o_last_result <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_p   <= '0;
                        unique case (i_job.kind)
                            JOB_STAGED: begin
                                o_strobe <= 1'b1;
                                o_status <= ST_STAGED;
                            end
                            JOB_TOOLONG: begin
                                o_strobe <= 1'b1;
                                o_status <= ST_TOOLONG;
                            end
                            default: r_state <= S_FKEY;
                        endcase
                    end
                end
                S_FKEY: begin
                    if (r_p >= r_pe) begin
                        if (r_job.kind == JOB_PUT) begin
                            r_state <= S_APCHK;
                        end else begin
                            o_strobe <= 1'b1;
                            o_status <= ST_NOTFOUND;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_FLEN;
                    end
                end
                S_FLEN: begin
                    r_hit   <= r_rdata == r_job.key;
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    r_l <= cur_l;
                    if (!r_hit) begin
                        r_p     <= r_p + PTR_W'(rec_words(cur_l));
                        r_state <= S_FKEY;
                    end else begin
                        priority case (r_job.kind)
                            JOB_TEST: begin
                                o_strobe <= 1'b1;
                                o_found  <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                            JOB_GET: begin
                                r_k  <= '0;
                                r_gv <= 1'b0;
                                if (cur_l == '0) begin
                                    o_strobe <= 1'b1;
                                    o_found  <= 1'b1;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_state <= S_GET;
                                end
                            end
                            default: begin
                                r_src   <= r_p + PTR_W'(rec_words(cur_l));
                                r_dst   <= r_p;
                                r_mv    <= 1'b0;
                                r_rw    <= rec_words(cur_l);
                                r_rc    <= rec_cost(cur_l);
                                r_state <= S_MOVE;
                            end
                        endcase
                    end
                end
                S_MOVE: begin
                    r_mv <= mv_rd;
                    if (mv_rd) r_src <= r_src + PTR_W'(1);
                    if (r_mv)  r_dst <= r_dst + PTR_W'(1);
                    if (!mv_rd && !r_mv) begin
                        r_pe   <= r_pe - PTR_W'(r_rw);
                        r_free <= r_free + REG_W'(r_rc);
                        if (r_job.kind == JOB_PUT) begin
                            r_state <= S_APCHK;
                        end else begin
                            o_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_APCHK: begin
                    if (put_fail) begin
                        o_strobe <= 1'b1;
                        o_status <= ST_NOSPACE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_APLEN;
                    end
                end
                S_APLEN: begin
                    r_k     <= '0;
                    r_wk    <= '0;
                    r_sv    <= 1'b0;
                    r_state <= S_APDAT;
                end
                S_APDAT: begin
                    r_sv <= ap_rd;
                    if (ap_rd) r_k  <= r_k + NW_W'(1);
                    if (r_sv)  r_wk <= r_wk + NW_W'(1);
                    if (!ap_rd && !r_sv) r_state <= S_APTAIL;
                end
                S_APTAIL: begin
                    r_pe     <= r_pe + PTR_W'(rec_words(r_job.len));
                    r_free   <= r_free - REG_W'(put_c);
                    o_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_GET: begin
                    r_gv <= g_rd;
                    if (g_rd) begin
                        r_k     <= r_k + NW_W'(1);
                        r_gnb   <= (g_rem > LEN_W'(8)) ? 4'd8 : g_rem[3:0];
                        r_glast <= (r_k + NW_W'(1)) == g_nw;
                    end
                    if (r_gv) begin
                        o_strobe      <= 1'b1;
                        o_found       <= 1'b1;
                        o_value_word  <= r_rdata & byte_mask(r_gnb);
                        o_value_bytes <= r_gnb;
                        o_last_result <= r_glast;
                        if (r_glast) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pe <= PTR_W'(MEM_WORDS))
        else $error("word end pointer past memory");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (o_status == ST_OK))
        else $error("found with bad status");
    a_bytes_only_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_value_bytes == 4'd0 && o_value_word == 64'd0))
        else $error("value bytes outside get");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_commit_done |=> (r_state == S_IDLE))
        else $error("commit done without return to idle");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pkrs_pkg::*;

    typedef struct {
        t_status     status;
        logic        found;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_result;

    class store_scoreboard;
        localparam int PHYS = MEM_BYTES / 4;
        logic [63:0] words_mem [PHYS];
        int unsigned top_word;
        int unsigned end_off;
        int unsigned free_room;
        int unsigned region;
        logic [7:0]  stage [MAX_VALUE_BYTES];
        int unsigned stage_len;
        bit          stage_ovf;
        t_result     pending [$];
        int          errors;
        int          checked;

        function new();
            region = 8192;
            errors = 0;
            checked = 0;
            empty_store();
        endfunction

        function void empty_store();
            int unsigned eff;
            eff = region > MEM_BYTES ? MEM_BYTES : region;
            foreach (words_mem[i]) words_mem[i] = '0;
            top_word = 0;
            end_off = AREA_HEADER_BYTES;
            free_room = eff > AREA_HEADER_BYTES ? eff - AREA_HEADER_BYTES : 0;
            stage_len = 0;
            stage_ovf = 0;
        endfunction

        function void set_region(logic [REG_W-1:0] v);
            region = v;
            empty_store();
        endfunction

        function int unsigned cost_of(int unsigned len);
            return ((len + CHUNK_HEADER_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES + ALIGN_BYTES;
        endfunction

        function int unsigned words_of(int unsigned len);
            return 2 + (len + 7) / 8;
        endfunction

        function int unsigned len_at(int unsigned p);
            int unsigned l;
            l = words_mem[p+1][15:0];
            return l > MAX_VALUE_BYTES ? MAX_VALUE_BYTES : l;
        endfunction

        function bit lookup(logic [63:0] key, output int unsigned where);
            int unsigned p, pos, l;
            p = 0;
            pos = AREA_HEADER_BYTES;
            where = 0;
            while (pos < end_off && p + 2 <= top_word && p + 2 <= PHYS) begin
                l = len_at(p);
                if (words_mem[p] == key) begin
                    where = p;
                    return 1;
                end
                pos += cost_of(l);
                p += words_of(l);
            end
            return 0;
        endfunction

        function void drop_record(int unsigned p);
            int unsigned l, w, c, from;
            l = len_at(p);
            w = words_of(l);
            c = cost_of(l);
            from = p + w > top_word ? top_word : p + w;
            for (int unsigned i = 0; i < top_word - from; i++)
                words_mem[p+i] = words_mem[from+i];
            top_word -= from - p;
            end_off = end_off > c ? end_off - c : 0;
            free_room += c;
        endfunction

        function void push(t_status st, logic fd, logic [63:0] w, logic [3:0] nb, logic lst);
            t_result r;
            r.status = st;
            r.found = fd;
            r.word = w;
            r.nbytes = nb;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note(t_cmd cmd, logic [63:0] key, logic [63:0] data,
                           logic [3:0] cnt, logic lastw);
            int unsigned n, p, len, c, w, nw, nb;
            logic [63:0] v;
            p = 0;
            if (cmd == CMD_PUT) begin
                n = cnt > 8 ? 8 : cnt;
                if (stage_ovf || stage_len + n > MAX_VALUE_BYTES) stage_ovf = 1;
                else begin
                    for (int unsigned i = 0; i < n; i++) stage[stage_len+i] = data[8*i +: 8];
                    stage_len += n;
                end
                if (!lastw) begin
                    push(ST_STAGED, 0, '0, '0, 1);
                    return;
                end
                if (stage_ovf) begin
                    stage_len = 0;
                    stage_ovf = 0;
                    push(ST_TOOLONG, 0, '0, '0, 1);
                    return;
                end
                len = stage_len;
                stage_len = 0;
                stage_ovf = 0;
                if (lookup(key, p)) drop_record(p);
                c = cost_of(len);
                w = words_of(len);
                if (free_room < c || top_word + w > PHYS) begin
                    push(ST_NOSPACE, 0, '0, '0, 1);
                    return;
                end
                p = top_word;
                words_mem[p] = key;
                words_mem[p+1] = len;
                for (int unsigned i = 0; i < w - 2; i++) words_mem[p+2+i] = '0;
                for (int unsigned i = 0; i < len; i++)
                    words_mem[p+2+i/8][8*(i%8) +: 8] = stage[i];
                top_word += w;
                end_off += c;
                free_room -= c;
                push(ST_OK, 0, '0, '0, 1);
                return;
            end
            stage_len = 0;
            stage_ovf = 0;
            if (!lookup(key, p)) begin
                push(ST_NOTFOUND, 0, '0, '0, 1);
                return;
            end
            if (cmd == CMD_TEST) begin
                push(ST_OK, 1, '0, '0, 1);
                return;
            end
            if (cmd == CMD_REMOVE) begin
                drop_record(p);
                push(ST_OK, 0, '0, '0, 1);
                return;
            end
            len = len_at(p);
            nw = (len + 7) / 8;
            if (nw == 0) begin
                push(ST_OK, 1, '0, '0, 1);
                return;
            end
            for (int unsigned k = 0; k < nw; k++) begin
                nb = len - 8 * k > 8 ? 8 : len - 8 * k;
                v = p + 2 + k < PHYS ? words_mem[p+2+k] : '0;
                v &= byte_mask(4'(nb));
                push(ST_OK, 1, v, 4'(nb), k + 1 == nw);
            end
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        function void check(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.found !== e.found)
                report($sformatf("found %0b, want %0b", got.found, e.found));
            if (got.word !== e.word)
                report($sformatf("value_word %h, want %h", got.word, e.word));
            if (got.nbytes !== e.nbytes)
                report($sformatf("value_bytes %0d, want %0d", got.nbytes, e.nbytes));
            if (got.last !== e.last)
                report($sformatf("last_result %0b, want %0b", got.last, e.last));
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_start = 0;
    logic              o_busy;
    logic [1:0]        i_command = '0;
    logic signed [63:0] i_key = '0;
    logic [63:0]       i_data_word = '0;
    logic [3:0]        i_byte_count = '0;
    logic              i_last_word = 0;
    logic              i_cfg_we = 0;
    logic [REG_W-1:0]  i_cfg_wdata = '0;
    logic              o_strobe;
    logic [2:0]        o_status;
    logic              o_found;
    logic [63:0]       o_value_word;
    logic [3:0]        o_value_bytes;
    logic              o_last_result;

    store_scoreboard sb = new();
    int unsigned transfers = 0;
    int unsigned cycles = 0;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    logic [63:0] key_pool [8];

    packed_keyed_record_store uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_key(i_key), .i_data_word(i_data_word),
        .i_byte_count(i_byte_count), .i_last_word(i_last_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe), .o_status(o_status), .o_found(o_found),
        .o_value_word(o_value_word), .o_value_bytes(o_value_bytes),
        .o_last_result(o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_result r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[packed_keyed_record_store] ERROR");
            $finish;
        end
        if (i_rst_n && i_start && !o_busy) begin
            sb.note(t_cmd'(i_command), i_key, i_data_word, i_byte_count, i_last_word);
            transfers++;
        end
        if (i_rst_n && o_strobe) begin
            r.status = t_status'(o_status);
            r.found = o_found;
            r.word = o_value_word;
            r.nbytes = o_value_bytes;
            r.last = o_last_result;
            sb.check(r);
        end
    end

    task automatic send(t_cmd cmd, logic [63:0] key, logic [63:0] data,
                        logic [3:0] cnt, logic lastw);
        int unsigned gap, seen;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_command = cmd;
        i_key = key;
        i_data_word = data;
        i_byte_count = cnt;
        i_last_word = lastw;
        i_start = 1;
        seen = transfers;
        do @(negedge i_clk); while (transfers == seen);
    endtask

    task automatic drain();
        i_start = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_region(logic [REG_W-1:0] v);
        drain();
        i_cfg_wdata = v;
        i_cfg_we = 1;
        sb.set_region(v);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // value of nbytes split over words, all with full byte counts but the last
    task automatic put_value(logic [63:0] key, int unsigned nbytes);
        int unsigned nw;
        nw = nbytes == 0 ? 1 : (nbytes + 7) / 8;
        for (int unsigned k = 0; k < nw; k++)
            send(CMD_PUT, k + 1 == nw ? key : {$urandom, $urandom}, {$urandom, $urandom},
                 k + 1 == nw ? 4'(nbytes - 8 * k) : 4'd8, k + 1 == nw);
    endtask

    task automatic random_put(logic [63:0] key);
        int unsigned nw;
        logic [3:0] cnt;
        nw = $urandom_range(0, 15) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 5);
        for (int unsigned k = 0; k < nw; k++) begin
            cnt = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'd8;
            send(CMD_PUT, k + 1 == nw ? key : {$urandom, $urandom},
                 {$urandom, $urandom}, cnt, k + 1 == nw);
        end
    endtask

    initial begin
        int unsigned sent_goal, r;
        logic [63:0] k;
        key_pool[0] = 64'h8000_0000_0000_0000;
        key_pool[1] = 64'h7fff_ffff_ffff_ffff;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed
        put_value(key_pool[0], 0);
        send(CMD_GET, key_pool[0], '0, '0, 0);
        send(CMD_PUT, key_pool[1], '1, 4'd15, 1);
        send(CMD_GET, key_pool[1], '0, '0, 0);
        put_value(key_pool[4], 21);
        send(CMD_GET, key_pool[4], '0, '0, 0);
        send(CMD_TEST, key_pool[4], '0, '0, 0);
        send(CMD_TEST, key_pool[5], '0, '0, 0);
        send(CMD_GET, key_pool[5], '0, '0, 0);
        put_value(key_pool[4], 256);
        send(CMD_GET, key_pool[4], '0, '0, 0);
        put_value(key_pool[2], 257);
        send(CMD_PUT, key_pool[3], '1, 4'd8, 0);
        send(CMD_TEST, key_pool[3], '0, '0, 0);
        send(CMD_REMOVE, key_pool[0], '0, '0, 0);
        send(CMD_REMOVE, key_pool[0], '0, '0, 0);
        send(CMD_GET, key_pool[1], '0, '0, 0);
        write_region(14'd40);
        send(CMD_PUT, key_pool[2], '0, 4'd0, 1);
        write_region(14'd0);
        send(CMD_PUT, key_pool[2], '0, 4'd0, 1);
        write_region(14'd120);
        put_value(key_pool[6], 8);
        put_value(key_pool[6], 40);
        send(CMD_TEST, key_pool[6], '0, '0, 0);

        // random phases over several region sizes
        sent_goal = transfers + 160;
        while (transfers < sent_goal) begin
            if (transfers > sent_goal - 120 && sb.region == 120) write_region(14'd16383);
            if (transfers > sent_goal - 70 && sb.region == 16383) write_region(14'd400);
            if (transfers > sent_goal - 30 && sb.region == 400) write_region(14'd8192);
            r = $urandom_range(0, 9);
            k = $urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(0, 7)];
            if (r < 5) random_put(k);
            else if (r == 5) send(CMD_PUT, k, {$urandom, $urandom},
                                  4'($urandom_range(0, 15)), 0);
            else send(t_cmd'($urandom_range(1, 3)), k, '0, '0, 0);
        end

        drain();
        $display("%0d transfers sent, %0d results checked", transfers, sb.checked);
        $display("puts, gets, tests, removes over regions 0, 40, 120, 400, 8192, 16383");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[packed_keyed_record_store] OK");
        else
            $display("[packed_keyed_record_store] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/pkrs_pkg.sv
hw/rtl/pkrs_front.sv
hw/rtl/pkrs_jobq.sv
hw/rtl/pkrs_back.sv
hw/rtl/packed_keyed_record_store.sv
dv/tb_top.sv
